### hdl/audio_range_cache_lookup_core_macros.svh
// Assertion helpers for the range cache.
`ifndef AUDIO_RANGE_CACHE_LOOKUP_CORE_MACROS_SVH
`define AUDIO_RANGE_CACHE_LOOKUP_CORE_MACROS_SVH
`ifndef SYNTH
`define ARC_ASSERT_IMPL(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
`define ARC_ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ARC_ASSERT_IMPL(lbl, clk, rstn, a, c)
`define ARC_ASSERT_NEXT(lbl, clk, rstn, a, c)
`endif
`endif

### hdl/arcl_pkg.sv
package arcl_pkg;
  localparam int unsigned DepthDef = 64;
  localparam int unsigned MtfDist = 16;
  localparam logic [31:0] MaxBlockReset = 32'd23040000;
  localparam logic [47:0] CapacityReset = 48'd1073741824;
  localparam logic [0:0] CfgMaxBlock = 1'b0;
  localparam logic [0:0] CfgCapacity = 1'b1;

  typedef struct packed {
    logic        valid;
    logic [15:0] source;
    logic [39:0] start;
    logic [39:0] fin;
    logic [31:0] bytes;
    logic [7:0]  slot;
  } entry_t;

  // Chain command to every cell
  typedef enum logic [1:0] {
    CMD_HOLD  = 2'd0,
    CMD_SHIFT = 2'd1,
    CMD_PUSH  = 2'd2,
    CMD_DROP  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [8:0]  limit;
    entry_t      head;
  } chain_ctl_t;
endpackage

### hdl/arcl_cell.sv
// One list position. Shift acts on positions up to limit, push on every
// position; drop clears the position equal to limit.
module arcl_cell #(
  parameter int unsigned POS = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  arcl_pkg::chain_ctl_t ctl,
  input  arcl_pkg::entry_t    prev,
  output arcl_pkg::entry_t    cur
);
  import arcl_pkg::*;
  entry_t e_r, e_nxt;
  logic [8:0] pos9;

  assign pos9 = 9'(POS);
  assign cur = e_r;

  always_comb begin
    e_nxt = e_r;
    case (ctl.cmd)
      CMD_SHIFT: if (pos9 <= ctl.limit) e_nxt = (pos9 == 9'd0) ? ctl.head : prev;
      CMD_PUSH:  e_nxt = (pos9 == 9'd0) ? ctl.head : prev;
      CMD_DROP:  if (pos9 == ctl.limit) e_nxt.valid = 1'b0;
      default:   e_nxt = e_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_r <= '0;
    end else begin
      e_r <= e_nxt;
    end
  end
endmodule

### hdl/arcl_divider.sv
// Restoring divider, one quotient bit a cycle.
module arcl_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] dividend,
  input  logic [6:0]  divisor,
  output logic        done,
  output logic [31:0] quotient
);
  logic [31:0] q_r;
  logic [6:0]  rem_r, d_r;
  logic [5:0]  cnt_r;
  logic        run_r, done_r;
  logic [7:0]  trial;

  assign trial = {rem_r, q_r[31]};
  assign done = done_r;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        q_r <= dividend;
        rem_r <= '0;
        d_r <= divisor;
      end else if (run_r) begin
        if (trial >= {1'b0, d_r}) begin
          rem_r <= 7'(trial - {1'b0, d_r});
          q_r <= {q_r[30:0], 1'b1};
        end else begin
          rem_r <= trial[6:0];
          q_r <= {q_r[30:0], 1'b0};
        end
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          run_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

### hdl/audio_range_cache_lookup_core.sv
// Move-to-front range cache held in a chain of DEPTH cells. A request is
// accepted when start is high and busy is low; busy then stays high until the
// cycle of the result strobe, and out_valid marks the result for exactly one
// cycle, which the receiver cannot stall and must take. The list is scanned
// by rotating the chain once, one position a cycle; a hit then strobes its
// result, after a further shift that moves the entry to the front when it lies
// more than MtfDist positions back. A miss adds the block-size clip (the
// divider starts on every miss, but is waited for only when the new entry is
// too large), a drop of the back entry when the cache is full by bytes or by
// entries, and a second rotation that finds the lowest free slot.
// Configuration writes are taken only while idle.
module audio_range_cache_lookup_core #(
  parameter int unsigned DEPTH = arcl_pkg::DepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_source_id,
  input  logic [39:0] in_req_start,
  input  logic [39:0] in_req_end,
  input  logic [39:0] in_source_frames,
  input  logic [6:0]  in_frame_bytes,
  output logic        out_valid,
  output logic        out_hit,
  output logic [5:0]  out_slot,
  output logic [31:0] out_byte_offset,
  output logic [39:0] out_granted_end,
  output logic [31:0] out_byte_count,
  output logic        out_evicted,
  output logic [5:0]  out_evicted_slot,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  import arcl_pkg::*;
  `include "audio_range_cache_lookup_core_macros.svh"

  localparam int unsigned SlotW = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_PROD, S_HITMV, S_DIV, S_CLIP, S_EVICT, S_FREE,
    S_INS, S_OUT
  } state_t;

  state_t      st_r;
  logic [31:0] max_blk_r;
  logic [47:0] cap_r;
  logic [15:0] src_r;
  logic [39:0] rs_r, re_r, fr_r;
  logic [6:0]  fb_r;
  logic [8:0]  k_r, n_r;
  logic [8:0]  scan_pos;
  logic [47:0] used_r;
  logic        found_r;
  entry_t      hit_r;
  entry_t      tail_r;
  logic [8:0]  hitk_r;
  logic [39:0] end_r;
  logic [47:0] bytes_r;
  logic [DEPTH-1:0] used_map_r;
  logic [7:0]  slot_r;
  logic        ev_r;
  logic [5:0]  evs_r;
  logic        div_go;
  logic        div_done;
  logic [31:0] div_q;
  logic [31:0] off_r, cnt_r;

  chain_ctl_t  ctl;
  entry_t      cells [DEPTH];
  entry_t      back;

  assign cfg_ready = (st_r == S_IDLE) && !start;
  assign busy = (st_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_blk_r <= MaxBlockReset;
      cap_r <= CapacityReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CfgMaxBlock: max_blk_r <= cfg_data[31:0];
        CfgCapacity: cap_r <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    arcl_cell #(.POS(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl),
      .prev(g == 0 ? cells[0] : cells[(g == 0) ? 0 : g - 1]),
      .cur(cells[g])
    );
  end

  // Scan by full rotation: after DEPTH rotate steps the chain is restored.
  assign back = cells[DEPTH-1];
  assign scan_pos = 9'(DEPTH - 1) - k_r;

  arcl_divider u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .dividend(max_blk_r),
    .divisor(fb_r), .done(div_done), .quotient(div_q)
  );
  assign div_go = (st_r == S_PROD) && !found_r;

  logic match;
  assign match = back.valid && back.source == src_r && back.start <= rs_r &&
                 back.fin >= re_r;

  always_comb begin
    ctl = '0;
    ctl.cmd = CMD_HOLD;
    ctl.head = back;
    ctl.limit = 9'(DEPTH - 1);
    case (st_r)
      S_SCAN: ctl.cmd = CMD_SHIFT;
      S_FREE: ctl.cmd = CMD_SHIFT;
      S_HITMV: begin
        ctl.cmd = CMD_SHIFT;
        ctl.limit = hitk_r;
        ctl.head = hit_r;
      end
      S_EVICT: begin
        ctl.cmd = CMD_DROP;
        ctl.limit = 9'(n_r - 9'd1);
      end
      S_INS: begin
        ctl.cmd = CMD_PUSH;
        ctl.head.valid = 1'b1;
        ctl.head.source = src_r;
        ctl.head.start = rs_r;
        ctl.head.fin = end_r;
        ctl.head.bytes = bytes_r[31:0];
        ctl.head.slot = free_idx;
      end
      default: ctl.cmd = CMD_HOLD;
    endcase
  end

  logic [7:0] free_idx;
  always_comb begin
    free_idx = 8'd0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!used_map_r[i]) free_idx = 8'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_valid <= 1'b0;
      n_r <= '0;
      used_r <= '0;
    end else begin
      out_valid <= 1'b0;
      case (st_r)
        S_IDLE: if (start) begin
          src_r <= in_source_id;
          rs_r <= in_req_start;
          re_r <= in_req_end;
          fr_r <= in_source_frames;
          fb_r <= (in_frame_bytes == 7'd0) ? 7'd1 : in_frame_bytes;
          k_r <= '0;
          found_r <= 1'b0;
          ev_r <= 1'b0;
          evs_r <= '0;
          st_r <= S_SCAN;
        end
        S_SCAN: begin
          // back walks from the last position to the front, so the frontmost
          // match is the one kept
          if (scan_pos < n_r && match) begin
            found_r <= 1'b1;
            hit_r <= back;
            hitk_r <= scan_pos;
          end
          if (scan_pos == n_r - 9'd1) tail_r <= back;
          k_r <= k_r + 9'd1;
          if (k_r == 9'(DEPTH - 1)) st_r <= S_PROD;
        end
        S_PROD: begin
          if (found_r) begin
            off_r <= ((rs_r - hit_r.start) * fb_r) > 48'hFFFFFFFF ? 32'hFFFFFFFF :
                     32'((rs_r - hit_r.start) * fb_r);
            cnt_r <= (re_r <= rs_r) ? 32'd0 :
                     (((re_r - rs_r) * fb_r) > 48'hFFFFFFFF ? 32'hFFFFFFFF :
                     32'((re_r - rs_r) * fb_r));
            st_r <= (hitk_r > 9'(MtfDist)) ? S_HITMV : S_OUT;
          end else begin
            end_r <= (fr_r > rs_r) ? fr_r : rs_r;
            bytes_r <= {8'd0, ((fr_r > rs_r) ? fr_r - rs_r : 40'd0)} * fb_r;
            st_r <= S_DIV;
          end
        end
        S_HITMV: st_r <= S_OUT;
        S_DIV: begin
          if (bytes_r <= {16'd0, max_blk_r}) st_r <= S_CLIP;
          else if (div_done) begin
            bytes_r <= 48'(div_q * fb_r);
            end_r <= 40'(rs_r + div_q);
            st_r <= S_CLIP;
          end
        end
        S_CLIP: begin
          if ((used_r >= cap_r || n_r >= 9'(DEPTH)) && n_r != 0) begin
            ev_r <= 1'b1;
            evs_r <= tail_r.slot[5:0];
            used_r <= used_r - {16'd0, tail_r.bytes};
            st_r <= S_EVICT;
          end else st_r <= S_FREE;
          used_map_r <= '0;
          k_r <= '0;
        end
        S_EVICT: begin
          n_r <= n_r - 9'd1;
          st_r <= S_FREE;
        end
        S_FREE: begin
          if (back.valid) used_map_r[back.slot[SlotW-1:0]] <= 1'b1;
          k_r <= k_r + 9'd1;
          if (k_r == 9'(DEPTH - 1)) begin
            st_r <= S_INS;
          end
        end
        S_INS: begin
          slot_r <= free_idx;
          st_r <= S_OUT;
          n_r <= n_r + 9'd1;
          used_r <= used_r + bytes_r;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          out_hit <= found_r;
          out_slot <= found_r ? hit_r.slot[5:0] : slot_r[5:0];
          out_byte_offset <= found_r ? off_r : 32'd0;
          out_granted_end <= found_r ? re_r : end_r;
          out_byte_count <= found_r ? cnt_r : bytes_r[31:0];
          out_evicted <= ev_r;
          out_evicted_slot <= ev_r ? evs_r : 6'd0;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `ARC_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `ARC_ASSERT_IMPL(a_out_idle, clk, rst_n, out_valid, !busy)
  `ARC_ASSERT_IMPL(a_cfg_idle, clk, rst_n, cfg_ready, !busy)
  `ARC_ASSERT_IMPL(a_count, clk, rst_n, 1'b1, n_r <= 9'(DEPTH))
endmodule

### verif/audio_range_cache_lookup_core_checker.sv
module audio_range_cache_lookup_core_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] in_source_id,
  input  logic [39:0] in_req_start,
  input  logic [39:0] in_req_end,
  input  logic [39:0] in_source_frames,
  input  logic [6:0]  in_frame_bytes,
  input  logic        out_valid,
  input  logic        out_hit,
  input  logic [5:0]  out_slot,
  input  logic [31:0] out_byte_offset,
  input  logic [39:0] out_granted_end,
  input  logic [31:0] out_byte_count,
  input  logic        out_evicted,
  input  logic [5:0]  out_evicted_slot,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output int          fail_count,
  output int          lookups_pending
);
  import arcl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = DepthDef;

  typedef struct packed {
    logic        hit;
    logic [5:0]  slot;
    logic [31:0] byte_offset;
    logic [39:0] granted_end;
    logic [31:0] byte_count;
    logic        evicted;
    logic [5:0]  evicted_slot;
  } lookup_t;

  typedef struct {
    logic [15:0] source;
    logic [39:0] first;
    logic [39:0] last;
    logic [31:0] nbytes;
    int          slot;
  } range_t;

  range_t      ranges[$];
  logic [31:0] max_block;
  logic [47:0] capacity;
  logic [47:0] total_bytes;
  lookup_t     lookups_due[$];

  function automatic logic [31:0] clamp32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic lookup_t cache_lookup(logic [15:0] src, logic [39:0] st,
                                           logic [39:0] rend, logic [39:0] frames,
                                           logic [6:0] fb_in);
    lookup_t     r;
    range_t      e;
    logic [63:0] fb, len, nb, whole;
    logic [39:0] fin;
    bit          taken[Depth];
    int          pos, free;
    r = '0;
    fb = (fb_in == 0) ? 64'd1 : {57'd0, fb_in};
    for (pos = 0; pos < ranges.size(); pos++) begin
      e = ranges[pos];
      if (e.source == src && e.first <= st && e.last >= rend) begin
        r.hit = 1'b1;
        r.slot = e.slot[5:0];
        r.byte_offset = clamp32({24'd0, st - e.first} * fb);
        r.granted_end = rend;
        r.byte_count = (rend > st) ? clamp32({24'd0, rend - st} * fb) : 32'd0;
        // promote only entries lying far back
        if (pos > MtfDist) begin
          ranges.delete(pos);
          ranges.insert(0, e);
        end
        return r;
      end
    end
    len = (frames > st) ? {24'd0, frames - st} : 64'd0;
    nb = len * fb;
    fin = st + len[39:0];
    if (nb > {32'd0, max_block}) begin
      whole = {32'd0, max_block} / fb;
      nb = whole * fb;
      fin = st + whole[39:0];
    end
    if ((total_bytes >= capacity || ranges.size() >= Depth) && ranges.size() > 0) begin
      e = ranges[ranges.size() - 1];
      ranges.delete(ranges.size() - 1);
      r.evicted = 1'b1;
      r.evicted_slot = e.slot[5:0];
      total_bytes = total_bytes - {16'd0, e.nbytes};
    end
    foreach (ranges[i]) taken[ranges[i].slot] = 1'b1;
    free = 0;
    while (free < Depth && taken[free]) free++;
    if (free == Depth) free = 0;
    e.source = src;
    e.first = st;
    e.last = fin;
    e.nbytes = nb[31:0];
    e.slot = free;
    ranges.insert(0, e);
    total_bytes = total_bytes + nb[47:0];
    r.slot = free[5:0];
    r.granted_end = fin;
    r.byte_count = nb[31:0];
    return r;
  endfunction

  assign lookups_pending = lookups_due.size();

  always @(posedge clk) begin
    lookup_t want, got;
    if (!rst_n) begin
      ranges.delete();
      lookups_due.delete();
      max_block <= MaxBlockReset;
      capacity <= CapacityReset;
      total_bytes = '0;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CfgMaxBlock) max_block <= cfg_data[31:0];
        else capacity <= cfg_data;
      end
      if (start && !busy)
        lookups_due.push_back(cache_lookup(in_source_id, in_req_start, in_req_end,
                                           in_source_frames, in_frame_bytes));
      if (out_valid) begin
        got = {out_hit, out_slot, out_byte_offset, out_granted_end, out_byte_count,
               out_evicted, out_evicted_slot};
        if (lookups_due.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = lookups_due.pop_front();
          if (want !== got) begin
            if (fail_count < 10)
              $display("mismatch: exp hit=%b slot=%0d off=%0d end=%0d cnt=%0d ev=%b evs=%0d",
                       want.hit, want.slot, want.byte_offset, want.granted_end,
                       want.byte_count, want.evicted, want.evicted_slot,
                       "\n          got hit=%b slot=%0d off=%0d end=%0d cnt=%0d ev=%b evs=%0d",
                       got.hit, got.slot, got.byte_offset, got.granted_end,
                       got.byte_count, got.evicted, got.evicted_slot);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### verif/audio_range_cache_lookup_core_tb.sv
module audio_range_cache_lookup_core_tb;
  import arcl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_source_id = '0;
  logic [39:0] in_req_start = '0;
  logic [39:0] in_req_end = '0;
  logic [39:0] in_source_frames = '0;
  logic [6:0]  in_frame_bytes = '0;
  logic        out_valid, out_hit, out_evicted;
  logic [5:0]  out_slot, out_evicted_slot;
  logic [31:0] out_byte_offset, out_byte_count;
  logic [39:0] out_granted_end;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = CfgMaxBlock;
  logic [47:0] cfg_data = '0;
  int          fail_count, lookups_pending;
  int          cycles = 0;
  bit          calm = 1'b0;

  localparam int CycleLimit = 1500000;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  audio_range_cache_lookup_core DUT (.*);
  audio_range_cache_lookup_core_checker u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (lookups_pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic send_request(logic [15:0] src, logic [39:0] st, logic [39:0] rend,
                              logic [39:0] frames, logic [6:0] fb);
    if (!calm && $urandom_range(3) == 0) repeat ($urandom_range(13, 1)) @(negedge clk);
    @(negedge clk);
    start <= 1'b1;
    in_source_id <= src;
    in_req_start <= st;
    in_req_end <= rend;
    in_source_frames <= frames;
    in_frame_bytes <= fb;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start <= 1'b0;
  endtask

  // mostly a few sources with small lengths so hits and evictions recur
  task automatic random_request();
    logic [15:0] src;
    logic [39:0] st, rend, frames;
    int kind;
    kind = $urandom_range(9);
    src = (kind < 8) ? 16'($urandom_range(5)) : 16'($urandom);
    st = (kind < 7) ? 40'($urandom_range(2000)) : {8'($urandom), 32'($urandom)};
    rend = st + 40'($urandom_range(300)) + 40'(kind == 9 ? 40'($urandom) : 0);
    frames = (kind == 6) ? st - 40'($urandom_range(3)) : st + 40'($urandom_range(3000));
    if (kind == 8) frames = {8'($urandom), 32'($urandom)};
    send_request(src, st, rend, frames, 7'($urandom_range(64, 0)));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    drain();
    // edges of the fields
    send_request(16'd0, 40'd0, 40'd1, 40'd0, 7'd0);
    send_request(16'hFFFF, 40'hFF_FFFF_FFFE, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 7'd64);
    send_request(16'd1, 40'd0, 40'd100, 40'd1000, 7'd4);
    send_request(16'd1, 40'd10, 40'd50, 40'd1000, 7'd4);
    send_request(16'd1, 40'd20, 40'd20, 40'd1000, 7'd4);
    send_request(16'd1, 40'd30, 40'd5, 40'd1000, 7'd127);
    send_request(16'd2, 40'd500, 40'd600, 40'd400, 7'd8);
    send_request(16'd3, 40'd0, 40'd10, 40'hFF_FFFF_FFFF, 7'd64);
    send_request(16'd3, 40'd0, 40'h80_0000_0000, 40'hFF_FFFF_FFFF, 7'd64);
    send_request(16'd3, 40'd100000, 40'd100001, 40'd200000, 7'd64);
    drain();
    write_reg(CfgMaxBlock, 48'd0);
    write_reg(CfgCapacity, 48'd0);
    send_request(16'd4, 40'd5, 40'd9, 40'd50, 7'd3);
    send_request(16'd4, 40'd5, 40'd5, 40'd50, 7'd3);
    send_request(16'd5, 40'd5, 40'd9, 40'd50, 7'd3);
    drain();
    write_reg(CfgMaxBlock, 48'hFFFF_FFFF);
    write_reg(CfgCapacity, 48'hFFFF_FFFF_FFFF);
    send_request(16'd6, 40'd0, 40'd1, 40'hFF_FFFF_FFFF, 7'd64);
    send_request(16'd6, 40'h10_0000_0000, 40'h10_0000_0001, 40'hFF_FFFF_FFFF, 7'd64);
    drain();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin write_reg(CfgMaxBlock, 48'd1000); write_reg(CfgCapacity, 48'd30000); end
        1: begin write_reg(CfgMaxBlock, 48'd1); write_reg(CfgCapacity, 48'hFFFF_FFFF_FFFF); end
        2: begin write_reg(CfgMaxBlock, 48'($urandom)); write_reg(CfgCapacity, 48'd5000); end
        3: begin write_reg(CfgMaxBlock, 48'd20000); write_reg(CfgCapacity, 48'($urandom)); end
        default: begin
          write_reg(CfgMaxBlock, 48'd23040000);
          write_reg(CfgCapacity, 48'd1073741824);
          calm = 1'b1;
        end
      endcase
      for (int n = 0; n < 250; n++) begin
        random_request();
        if (phase == 2 && n == 100) while (lookups_pending != 0) @(posedge clk);
      end
      drain();
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
